[design/pphc_pkg.sv]
// Shared types, register map and arithmetic helpers for the proximity push
// hover controller. No dependencies; imported by the core module.
package pphc_pkg;

    // Field widths
    localparam int DIST_W   = 16;
    localparam int RAD_W    = 12;
    localparam int GAIN_W   = 16;
    localparam int STEP_W   = 10;
    localparam int LAND_W   = 16;
    localparam int VEL_W    = 16;
    localparam int HEIGHT_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    // Craft operating mode
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_LOW      = 2'd1,
        MODE_UNLOCKED = 2'd2,
        MODE_STOPPING = 2'd3
    } mode_t;

    // Kind of setpoint issued for one beat
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_HOVER = 2'd2
    } kind_t;

    // Input command selector
    localparam logic CMD_PEER = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PUSH_RADIUS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GESTURE_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOPPED_UP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_STEP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_HEIGHT    = 3'd7;

    // Register and state reset values
    localparam logic [RAD_W-1:0]  RST_PUSH_RADIUS    = 12'd300;
    localparam logic [RAD_W-1:0]  RST_GESTURE_RADIUS = 12'd100;
    localparam logic [RAD_W-1:0]  RST_UNLOCK_LOW     = 12'd100;
    localparam logic [RAD_W-1:0]  RST_UNLOCK_HIGH    = 12'd300;
    localparam logic [RAD_W-1:0]  RST_STOPPED_UP     = 12'd500;
    localparam logic [GAIN_W-1:0] RST_VELOCITY_GAIN  = 16'd853;
    localparam logic [STEP_W-1:0] RST_HEIGHT_STEP    = 10'd20;
    localparam logic [LAND_W-1:0] RST_LAND_HEIGHT    = 16'd500;
    localparam logic signed [HEIGHT_W-1:0] RST_HEIGHT = 20'sd4000;
    localparam logic [DIST_W-1:0] RST_PEER_DIST      = 16'd1000;

    // Push radius minus the smaller of a combined distance and that radius, as intrusion depth
    function automatic logic [RAD_W-1:0] intrusion(input logic [DIST_W-1:0] d,
                                                   input logic [RAD_W-1:0] rad);
        logic [RAD_W-1:0] near;
        near = (d < {4'd0, rad}) ? d[RAD_W-1:0] : rad;
        return rad - near;
    endfunction

    // Repulsive velocity: sign of (pos - neg), magnitude rounded and saturated
    function automatic logic [VEL_W-1:0] push_vel(input logic [RAD_W-1:0] i_pos,
                                                  input logic [RAD_W-1:0] i_neg,
                                                  input logic [GAIN_W-1:0] gain);
        logic        neg;
        logic [11:0] diff;
        logic [27:0] prod;
        logic [28:0] rnd;
        logic [20:0] mag;
        logic [15:0] v;
        neg  = i_neg > i_pos;
        diff = neg ? (i_neg - i_pos) : (i_pos - i_neg);
        prod = diff * gain;
        rnd  = {1'b0, prod} + 29'd128;
        mag  = rnd[28:8];
        if (neg) begin
            v = (mag > 21'd32768) ? 16'h8000 : 16'(16'd0 - mag[15:0]);
        end else begin
            v = (mag > 21'd32767) ? 16'h7FFF : mag[15:0];
        end
        return v;
    endfunction

    // Clamp a wide signed height to the 20-bit signed range
    function automatic logic [HEIGHT_W-1:0] sat20(input logic signed [22:0] v);
        logic [HEIGHT_W-1:0] r;
        if (v > 23'sd524287) begin
            r = 20'h7FFFF;
        end else if (v < -23'sd524288) begin
            r = 20'h80000;
        end else begin
            r = v[HEIGHT_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/proximity_push_hover_controller_core.sv]
// Proximity push hover controller: peer distance store, mode sequencer and
// hover setpoint datapath. Depends on pphc_pkg.
//
//  Channel  Dir  Handshake            Payload
//  s_       in   s_tvalid/s_tready    tdata: five distances, ready flags; tuser: cmd
//  m_       out  m_tvalid/m_tready    tdata: velocities, height, mode; tuser: kind
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One beat is taken every cycle while the m_ side does not stall; each accepted
//  beat yields one result beat (input register, then result register).
//  The peer distances, mode and height setpoint update when a beat moves
//  from the input register into the result register.
//  A stalled m_ side holds the result register; the input register fills
//  and s_tready drops only when both are occupied.
//  aresetn is synchronous, active low; cfg_ready is always high.
module proximity_push_hover_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // dist_up, dist_front, dist_back, dist_left, dist_right (16 each),
    // positioning_ready, ranger_ready, zero pad
    input  logic [pphc_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [pphc_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vel_forward (16), vel_side (16), target_height (20), mode (2), zero pad
    output logic [pphc_pkg::M_TDATA_W-1:0]  m_tdata,
    // setpoint_kind
    output logic [pphc_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pphc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pphc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pphc_pkg::*;

    // Configuration registers
    logic [RAD_W-1:0]  push_radius_reg;
    logic [RAD_W-1:0]  gesture_radius_reg;
    logic [RAD_W-1:0]  unlock_low_reg;
    logic [RAD_W-1:0]  unlock_high_reg;
    logic [RAD_W-1:0]  stopped_up_reg;
    logic [GAIN_W-1:0] velocity_gain_reg;
    logic [STEP_W-1:0] height_step_reg;
    logic [LAND_W-1:0] land_height_reg;

    // Input register
    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [DIST_W-1:0] in_up_reg, in_front_reg, in_back_reg, in_left_reg, in_right_reg;
    logic              in_pos_ready_reg, in_rng_ready_reg;

    // Persistent state
    mode_t                mode_reg, mode_next;
    logic [HEIGHT_W-1:0]  height_reg, height_next;
    logic [DIST_W-1:0]    peer_up_reg, peer_front_reg, peer_back_reg;
    logic [DIST_W-1:0]    peer_left_reg, peer_right_reg;

    // Result register
    logic                 out_valid_reg;
    kind_t                out_kind_reg, kind_next;
    logic [VEL_W-1:0]     out_vf_reg, vf_next;
    logic [VEL_W-1:0]     out_vs_reg, vs_next;
    logic [HEIGHT_W-1:0]  out_th_reg, th_next;
    mode_t                out_mode_reg;

    logic advance;
    logic take;

    // Result register free or draining this cycle
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Step logic for the beat held in the input register
    always_comb begin
        logic [DIST_W-1:0]     up, fr, bk, lf, rt;
        logic [RAD_W-1:0]      i_up, i_fr, i_bk, i_lf, i_rt;
        logic [HEIGHT_W-1:0]   h1, h2;
        logic [16:0]           up_o10;
        logic signed [22:0]    wide;
        mode_t                 m1, m2, m3;

        up = (in_up_reg    < peer_up_reg)    ? in_up_reg    : peer_up_reg;
        fr = (in_front_reg < peer_front_reg) ? in_front_reg : peer_front_reg;
        bk = (in_back_reg  < peer_back_reg)  ? in_back_reg  : peer_back_reg;
        lf = (in_left_reg  < peer_left_reg)  ? in_left_reg  : peer_left_reg;
        rt = (in_right_reg < peer_right_reg) ? in_right_reg : peer_right_reg;

        i_up = intrusion(up, push_radius_reg);
        i_fr = intrusion(fr, push_radius_reg);
        i_bk = intrusion(bk, push_radius_reg);
        i_lf = intrusion(lf, push_radius_reg);
        i_rt = intrusion(rt, push_radius_reg);

        // Raise on paired side hands
        h1 = height_reg;
        if (lf < {4'd0, gesture_radius_reg} && rt < {4'd0, gesture_radius_reg}) begin
            wide = {{3{height_reg[HEIGHT_W-1]}}, height_reg} + {13'd0, height_step_reg};
            h1   = sat20(wide);
        end
        // Lower on paired front/back hands or anything above
        h2 = h1;
        if ((fr < {4'd0, gesture_radius_reg} && bk < {4'd0, gesture_radius_reg})
            || up < {4'd0, push_radius_reg}) begin
            wide = {{3{h1[HEIGHT_W-1]}}, h1} - {13'd0, height_step_reg};
            h2   = sat20(wide);
        end
        up_o10 = {2'd0, i_up, 3'd0} + {4'd0, i_up, 1'd0};
        wide   = {{3{h2[HEIGHT_W-1]}}, h2} - {6'd0, up_o10};

        // Mode sequence outside unlocked, each check sees the previous one
        m1 = mode_reg;
        if (m1 == MODE_STOPPING && up > {4'd0, stopped_up_reg}) begin
            m1 = MODE_IDLE;
        end
        m2 = m1;
        if (m2 == MODE_IDLE && up < {4'd0, unlock_low_reg} && up != '0) begin
            m2 = MODE_LOW;
        end
        m3 = m2;
        if (m3 == MODE_LOW && up > {4'd0, unlock_high_reg}
            && in_pos_ready_reg && in_rng_ready_reg) begin
            m3 = MODE_UNLOCKED;
        end

        mode_next   = mode_reg;
        height_next = height_reg;
        kind_next   = KIND_NONE;
        vf_next     = '0;
        vs_next     = '0;
        th_next     = '0;

        if (in_cmd_reg == CMD_TICK) begin
            if (mode_reg == MODE_UNLOCKED) begin
                vs_next     = push_vel(i_rt, i_lf, velocity_gain_reg);
                vf_next     = push_vel(i_bk, i_fr, velocity_gain_reg);
                height_next = h2;
                th_next     = sat20(wide);
                kind_next   = KIND_HOVER;
                if ($signed(th_next) < $signed({4'd0, land_height_reg})) begin
                    mode_next = MODE_STOPPING;
                end
            end else begin
                mode_next = m3;
                if (m3 == MODE_IDLE || m3 == MODE_STOPPING) begin
                    kind_next = KIND_ZERO;
                end
            end
        end
    end

    // Control state, stored state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            push_radius_reg    <= RST_PUSH_RADIUS;
            gesture_radius_reg <= RST_GESTURE_RADIUS;
            unlock_low_reg     <= RST_UNLOCK_LOW;
            unlock_high_reg    <= RST_UNLOCK_HIGH;
            stopped_up_reg     <= RST_STOPPED_UP;
            velocity_gain_reg  <= RST_VELOCITY_GAIN;
            height_step_reg    <= RST_HEIGHT_STEP;
            land_height_reg    <= RST_LAND_HEIGHT;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            mode_reg           <= MODE_IDLE;
            height_reg         <= RST_HEIGHT;
            peer_up_reg        <= RST_PEER_DIST;
            peer_front_reg     <= RST_PEER_DIST;
            peer_back_reg      <= RST_PEER_DIST;
            peer_left_reg      <= RST_PEER_DIST;
            peer_right_reg     <= RST_PEER_DIST;
        end else begin
            // Register writes, masked to each field's width
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PUSH_RADIUS:    push_radius_reg    <= cfg_data[RAD_W-1:0];
                    REG_GESTURE_RADIUS: gesture_radius_reg <= cfg_data[RAD_W-1:0];
                    REG_UNLOCK_LOW:     unlock_low_reg     <= cfg_data[RAD_W-1:0];
                    REG_UNLOCK_HIGH:    unlock_high_reg    <= cfg_data[RAD_W-1:0];
                    REG_STOPPED_UP:     stopped_up_reg     <= cfg_data[RAD_W-1:0];
                    REG_VELOCITY_GAIN:  velocity_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_HEIGHT_STEP:    height_step_reg    <= cfg_data[STEP_W-1:0];
                    REG_LAND_HEIGHT:    land_height_reg    <= cfg_data[LAND_W-1:0];
                    default: ;
                endcase
            end

            // Input register occupancy
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            // Result register occupancy
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            // Commit the step
            if (advance) begin
                mode_reg   <= mode_next;
                height_reg <= height_next;
                if (in_cmd_reg == CMD_PEER) begin
                    peer_up_reg    <= in_up_reg;
                    peer_front_reg <= in_front_reg;
                    peer_back_reg  <= in_back_reg;
                    peer_left_reg  <= in_left_reg;
                    peer_right_reg <= in_right_reg;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (take) begin
            in_cmd_reg       <= s_tuser[0];
            in_up_reg        <= s_tdata[15:0];
            in_front_reg     <= s_tdata[31:16];
            in_back_reg      <= s_tdata[47:32];
            in_left_reg      <= s_tdata[63:48];
            in_right_reg     <= s_tdata[79:64];
            in_pos_ready_reg <= s_tdata[80];
            in_rng_ready_reg <= s_tdata[81];
        end
        if (advance) begin
            out_kind_reg <= kind_next;
            out_vf_reg   <= vf_next;
            out_vs_reg   <= vs_next;
            out_th_reg   <= th_next;
            out_mode_reg <= mode_next;
        end
    end

    // Drive the result beat
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'd0, out_mode_reg, out_th_reg, out_vs_reg, out_vf_reg};

`ifndef ASSERT_OFF
    // A hover setpoint is only issued from unlocked, which leaves unlocked or stopping
    a_hover_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_kind_reg == KIND_HOVER) |->
            (out_mode_reg == MODE_UNLOCKED || out_mode_reg == MODE_STOPPING))
        else $error("hover setpoint with mode outside unlocked/stopping");

    // Without a hover setpoint the motion fields are zero
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_kind_reg != KIND_HOVER) |->
            (out_vf_reg == '0 && out_vs_reg == '0 && out_th_reg == '0))
        else $error("nonzero motion fields without hover setpoint");

    // Unlocked is left only for stopping
    a_unlock_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(mode_reg) == MODE_UNLOCKED && mode_reg != MODE_UNLOCKED) |->
            (mode_reg == MODE_STOPPING))
        else $error("unlocked left for a mode other than stopping");

    // Backpressure appears only with both registers occupied and the m_ side stalled
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without both stages occupied");

    // Stored state changes only when a beat is committed
    a_state_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(advance) && $past(aresetn) |-> ($stable(mode_reg) && $stable(height_reg)))
        else $error("mode or height changed without a committed beat");
`endif

endmodule
